>>> src/evphd_pkg.sv
// Package of shared types and constants for the exclusive valve peak-and-hold driver.
package evphd_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned DUTY_W     = 13;
  localparam int unsigned SECS_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_LANES  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_SECONDS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_OFF_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUTY        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_DUTY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DUTY        = 3'd4;

  localparam logic [SECS_W-1:0] PICKUP_SECONDS_RST   = 16'd1;
  localparam logic [SECS_W-1:0] AUTO_OFF_SECONDS_RST = 16'd600;
  localparam logic [DUTY_W-1:0] HOLD_DUTY_RST        = 13'd0;
  localparam logic [DUTY_W-1:0] PICKUP_DUTY_RST      = 13'd0;
  localparam logic [DUTY_W-1:0] IDLE_DUTY_RST        = 13'd8191;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_ON    = 2'd1,
    KIND_OFF   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_PICKUP = 2'd1,
    MODE_HOLD   = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [CH_W-1:0]  channel;
    logic             in_range;
  } cmd_t;

  typedef struct packed {
    logic [SECS_W-1:0] pickup_seconds;
    logic [SECS_W-1:0] auto_off_seconds;
    logic [DUTY_W-1:0] hold_duty;
    logic [DUTY_W-1:0] pickup_duty;
    logic [DUTY_W-1:0] idle_duty;
  } cfg_t;

endpackage

>>> src/evphd_if.sv
// Handshake interfaces for the command, result and configuration channels.
interface evphd_cmd_if
  import evphd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CH_W-1:0]   channel;

  modport source (output valid, output kind, output channel, input ready);
  modport sink   (input valid, input kind, input channel, output ready);
endinterface

interface evphd_res_if
  import evphd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [DUTY_W-1:0]    duty_ch0;
  logic [DUTY_W-1:0]    duty_ch1;
  logic [DUTY_W-1:0]    duty_ch2;
  logic [DUTY_W-1:0]    duty_ch3;
  logic [OUT_LANES-1:0] active_mask;
  logic                 status_event;
  logic                 queried_on;

  modport source (output valid, output duty_ch0, output duty_ch1, output duty_ch2,
                  output duty_ch3, output active_mask, output status_event,
                  output queried_on, input ready);
  modport sink   (input valid, input duty_ch0, input duty_ch1, input duty_ch2,
                  input duty_ch3, input active_mask, input status_event,
                  input queried_on, output ready);
endinterface

interface evphd_cfg_if
  import evphd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/exclusive_valve_peak_hold_driver_unit.sv
// Top level of the exclusive valve peak-and-hold driver: configuration registers and both ends.
//
// Usage: items arrive on cmd_i (kind, channel) and every item yields exactly one
// result item on res_o, holding the duty word of channels 0 to 3, the active mask,
// the status-event flag and, for a status query, whether the named channel is on.
// Configuration registers are written over cfg_i (index, data), which is always
// ready; writes are meant to happen only while no item is in flight.
// An accepted item is first written into the two-entry command queue; when nothing
// stalls, the back end then moves it from the queue into the result register.
// Throughput: one item per cycle while the receiver does not stall, set by the back end,
// which updates all channel modes and counters in parallel.
// When the receiver stalls, the result register holds its item and the queue keeps
// accepting until both of its entries are full, after which cmd_i.ready drops.
// Reset clears every channel to off with a zero counter, empties the queue and
// the result register, and loads the documented register reset values.
module exclusive_valve_peak_hold_driver_unit
  import evphd_pkg::*;
#(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  evphd_cmd_if.sink   cmd_i,
  evphd_cfg_if.sink   cfg_i,
  evphd_res_if.source res_o
);

  cfg_t cfg_q;
  logic head_valid;
  cmd_t head;
  logic pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pickup_seconds   <= PICKUP_SECONDS_RST;
      cfg_q.auto_off_seconds <= AUTO_OFF_SECONDS_RST;
      cfg_q.hold_duty        <= HOLD_DUTY_RST;
      cfg_q.pickup_duty      <= PICKUP_DUTY_RST;
      cfg_q.idle_duty        <= IDLE_DUTY_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PICKUP_SECONDS:   cfg_q.pickup_seconds   <= cfg_i.data;
        CFG_AUTO_OFF_SECONDS: cfg_q.auto_off_seconds <= cfg_i.data;
        CFG_HOLD_DUTY:        cfg_q.hold_duty        <= cfg_i.data[DUTY_W-1:0];
        CFG_PICKUP_DUTY:      cfg_q.pickup_duty      <= cfg_i.data[DUTY_W-1:0];
        CFG_IDLE_DUTY:        cfg_q.idle_duty        <= cfg_i.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  evphd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  evphd_back #(
    .CHANNELS  (CHANNELS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

>>> src/evphd_front.sv
// Front end: accepts command items, classifies them and queues them for the back end.
module evphd_front
  import evphd_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  evphd_cmd_if.sink         cmd_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output cmd_t              head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push;
  cmd_t       cls;

  assign cmd_i.ready  = (count_q != 2'd2);
  assign push         = cmd_i.valid && cmd_i.ready;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cls.kind     = kind_e'(cmd_i.kind);
    cls.channel  = cmd_i.channel;
    cls.in_range = (32'(cmd_i.channel) < CHANNELS);
  end

  always_comb begin
    count_d = count_q;
    case ({push, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

endmodule

>>> src/evphd_back.sv
// Back end: channel modes and counters, command execution and the result register.
module evphd_back
  import evphd_pkg::*;
#(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        head_valid_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  evphd_res_if.source res_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > SECS_W) ? COUNT_BITS : SECS_W;

  mode_e                 mode_q [CHANNELS];
  mode_e                 mode_d [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_q  [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_d  [CHANNELS];
  logic [COUNT_BITS-1:0] inc    [CHANNELS];
  logic [CHANNELS-1:0]   hit;
  logic                  ev, qry;

  logic                  valid_q;
  logic [DUTY_W-1:0]     duty_q [OUT_LANES];
  logic [DUTY_W-1:0]     duty_d [OUT_LANES];
  logic [OUT_LANES-1:0]  mask_q, mask_d;
  logic                  ev_q, qry_q;

  assign pop_o = head_valid_i && (!valid_q || res_o.ready);

  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    assign hit[g] = (head_i.channel == CH_W'(g));
    assign inc[g] = (&cnt_q[g]) ? cnt_q[g] : cnt_q[g] + COUNT_BITS'(1);
  end

  always_comb begin
    ev  = 1'b0;
    qry = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      mode_d[i] = mode_q[i];
      cnt_d[i]  = cnt_q[i];
      unique case (head_i.kind)
        KIND_TICK: begin
          if (mode_q[i] != MODE_OFF) begin
            cnt_d[i] = inc[i];
            if (CMP_W'(inc[i]) > CMP_W'(cfg_i.pickup_seconds) && mode_q[i] == MODE_PICKUP)
              mode_d[i] = MODE_HOLD;
            if (CMP_W'(inc[i]) > CMP_W'(cfg_i.auto_off_seconds)) begin
              mode_d[i] = MODE_OFF;
              cnt_d[i]  = '0;
              ev        = 1'b1;
            end
          end
        end
        KIND_ON: begin
          if (head_i.in_range) begin
            if (hit[i]) begin
              if (mode_q[i] == MODE_OFF) mode_d[i] = MODE_PICKUP;
            end else begin
              mode_d[i] = MODE_OFF;
            end
            cnt_d[i] = '0;
            ev       = 1'b1;
          end
        end
        KIND_OFF: begin
          if (head_i.in_range) begin
            if (hit[i]) begin
              mode_d[i] = MODE_OFF;
              cnt_d[i]  = '0;
            end
            ev = 1'b1;
          end
        end
        KIND_QUERY: begin
          ev = 1'b1;
          if (hit[i] && mode_q[i] != MODE_OFF) qry = 1'b1;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < OUT_LANES; g++) begin : g_lane
    if (g < CHANNELS) begin : g_used
      always_comb begin
        unique case (mode_d[g])
          MODE_OFF:    duty_d[g] = cfg_i.idle_duty;
          MODE_PICKUP: duty_d[g] = cfg_i.pickup_duty;
          default:     duty_d[g] = cfg_i.hold_duty;
        endcase
        mask_d[g] = (mode_d[g] != MODE_OFF);
      end
    end else begin : g_unused
      assign duty_d[g] = cfg_i.idle_duty;
      assign mask_d[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        mode_q[i] <= MODE_OFF;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          mode_q[i] <= mode_d[i];
          cnt_q[i]  <= cnt_d[i];
        end
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      duty_q <= duty_d;
      mask_q <= mask_d;
      ev_q   <= ev;
      qry_q  <= qry;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.duty_ch0     = duty_q[0];
  assign res_o.duty_ch1     = duty_q[1];
  assign res_o.duty_ch2     = duty_q[2];
  assign res_o.duty_ch3     = duty_q[3];
  assign res_o.active_mask  = mask_q;
  assign res_o.status_event = ev_q;
  assign res_o.queried_on   = qry_q;

endmodule
